### hw/rtl/dptt_pkg.sv
// ----------------------------------------------------------------------------
// dptt_pkg
// Types and constants shared by the page table translator modules.
// ----------------------------------------------------------------------------
package dptt_pkg;

	localparam int ACTION_W         = 3;
	localparam int SPACE_W          = 3;
	localparam int LEN_W            = 32;
	localparam int PHYS_W           = 36;
	localparam int STATUS_W         = 2;
	localparam int COUNT_W          = 11;
	localparam int FIRST_FRAME_RESET = 256;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TRANSLATE = 3'd0,
		ACT_TOUCH     = 3'd1,
		ACT_MAP       = 3'd2,
		ACT_UNMAP     = 3'd3,
		ACT_SET_BREAK = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_TRANS,
		CMD_MAP,
		CMD_UNMAP
	} cmd_op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PAGE,
		BK_SCAN,
		BK_POST,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		cmd_op_t             op;
		logic                ok;
		logic                bypass;
		logic [SPACE_W-1:0]  space;
	} cmd_ctl_t;

	typedef struct packed {
		logic [PHYS_W-1:0]   phys_address;
		logic                hit;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  space_pages;
		logic [COUNT_W-1:0]  total_pages;
	} result_t;

endpackage

### hw/rtl/dptt_ram.sv
// ----------------------------------------------------------------------------
// dptt_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/dptt_fifo.sv
// ----------------------------------------------------------------------------
// dptt_fifo
// Small register queue used between the front, the back and the result side.
// ----------------------------------------------------------------------------
module dptt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### hw/rtl/dptt_front.sv
// ----------------------------------------------------------------------------
// dptt_front
// Decodes an incoming item into a page range command and keeps break ends.
// ----------------------------------------------------------------------------
module dptt_front #(
	parameter int NUM_SPACES = 8,
	parameter int PAGE_BITS  = 12,
	parameter int ADDR_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [dptt_pkg::ACTION_W-1:0]     action,
	input  logic [dptt_pkg::SPACE_W-1:0]      space_id,
	input  logic                              bypass,
	input  logic [ADDR_BITS-1:0]              address,
	input  logic [dptt_pkg::LEN_W-1:0]        length,
	input  logic                              adjust_break,
	output dptt_pkg::cmd_ctl_t                ctl,
	output logic [ADDR_BITS-PAGE_BITS:0]      start_vpn,
	output logic [ADDR_BITS-PAGE_BITS:0]      end_vpn
);

	localparam int VW = ADDR_BITS - PAGE_BITS;
	localparam int CW = (ADDR_BITS + 2 > dptt_pkg::LEN_W + 2) ? ADDR_BITS + 2
		: dptt_pkg::LEN_W + 2;
	localparam int SW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
	localparam logic [CW-1:0] LIMIT = {{(CW-1){1'b0}}, 1'b1} << VW;
	localparam logic [CW-1:0] ROUND = ({{(CW-1){1'b0}}, 1'b1} << PAGE_BITS)
		- {{(CW-1){1'b0}}, 1'b1};

	logic [ADDR_BITS-1:0] brk_q [NUM_SPACES];
	logic [SW-1:0]        sidx;
	logic                 ok;
	logic [ADDR_BITS-1:0] old_brk;
	logic [ADDR_BITS-1:0] base_addr;
	logic [ADDR_BITS-1:0] diff;
	logic [CW-1:0]        vpn;
	logic [CW-1:0]        pu_addr;
	logic [CW-1:0]        pu_old;
	logic [CW-1:0]        pu_len;
	logic [CW-1:0]        pu_diff;
	logic [CW-1:0]        start_raw;
	logic [CW-1:0]        count_raw;
	logic [CW-1:0]        start_c;
	logic [CW-1:0]        end_c;
	logic                 brk_we;
	logic [ADDR_BITS-1:0] brk_d;
	dptt_pkg::cmd_op_t    op;

	assign sidx      = SW'(space_id);
	assign ok        = 32'(space_id) < 32'(NUM_SPACES);
	assign old_brk   = brk_q[sidx];
	assign base_addr = {address[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
	assign diff      = (address > old_brk) ? address - old_brk : old_brk - address;
	assign vpn       = CW'(address[ADDR_BITS-1:PAGE_BITS]);
	assign pu_addr   = (CW'(address) + ROUND) >> PAGE_BITS;
	assign pu_old    = (CW'(old_brk) + ROUND) >> PAGE_BITS;
	assign pu_len    = (CW'(length) + ROUND) >> PAGE_BITS;
	assign pu_diff   = (CW'(diff) + ROUND) >> PAGE_BITS;

	always_comb begin
		op        = dptt_pkg::CMD_NOP;
		start_raw = vpn;
		count_raw = {{(CW-1){1'b0}}, 1'b1};
		brk_we    = 1'b0;
		brk_d     = address;
		unique case (action)
			dptt_pkg::ACT_TRANSLATE: begin
				op = dptt_pkg::CMD_TRANS;
			end
			dptt_pkg::ACT_TOUCH: begin
				if (ok) begin
					op = dptt_pkg::CMD_MAP;
				end
			end
			dptt_pkg::ACT_MAP: begin
				if (ok) begin
					op        = dptt_pkg::CMD_MAP;
					count_raw = pu_len;
					if (adjust_break && base_addr > old_brk) begin
						brk_we = 1'b1;
						brk_d  = ADDR_BITS'(CW'(base_addr) + (pu_len << PAGE_BITS));
					end
				end
			end
			dptt_pkg::ACT_UNMAP: begin
				if (ok) begin
					op        = dptt_pkg::CMD_UNMAP;
					start_raw = pu_addr;
					count_raw = pu_len;
				end
			end
			dptt_pkg::ACT_SET_BREAK: begin
				if (ok) begin
					brk_we = 1'b1;
					if (adjust_break && address > old_brk) begin
						op        = dptt_pkg::CMD_MAP;
						start_raw = pu_old;
						count_raw = pu_diff;
					end else if (adjust_break && address < old_brk) begin
						op        = dptt_pkg::CMD_UNMAP;
						start_raw = pu_addr;
						count_raw = pu_diff;
					end
				end
			end
			default: begin
				op = dptt_pkg::CMD_NOP;
			end
		endcase
	end

	// clip the range to the top of the address space
	always_comb begin
		if (start_raw >= LIMIT) begin
			start_c = LIMIT;
			end_c   = LIMIT;
		end else begin
			start_c = start_raw;
			end_c   = (count_raw > LIMIT - start_raw) ? LIMIT : start_raw + count_raw;
		end
	end

	assign ctl.op     = op;
	assign ctl.ok     = ok;
	assign ctl.bypass = bypass;
	assign ctl.space  = space_id;
	assign start_vpn  = start_c[VW:0];
	assign end_vpn    = end_c[VW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SPACES; i++) begin
				brk_q[i] <= '0;
			end
		end else if (accept && brk_we) begin
			brk_q[sidx] <= brk_d;
		end
	end

endmodule

### hw/rtl/dptt_back.sv
// ----------------------------------------------------------------------------
// dptt_back
// Executes commands against the page table by full passes over the table RAM.
// ----------------------------------------------------------------------------
module dptt_back #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int NUM_SPACES    = 8,
	parameter int PAGE_BITS     = 12,
	parameter int ADDR_BITS     = 32,
	parameter int FRAME_BITS    = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [FRAME_BITS-1:0]        cfg_data,
	input  logic                         cmd_valid,
	output logic                         cmd_pop,
	input  dptt_pkg::cmd_ctl_t           cmd_ctl,
	input  logic [ADDR_BITS-PAGE_BITS:0] cmd_start,
	input  logic [ADDR_BITS-PAGE_BITS:0] cmd_end,
	input  logic [ADDR_BITS-1:0]         cmd_addr,
	output logic                         res_push,
	input  logic                         res_full,
	output dptt_pkg::result_t            res,
	output logic                         clearing
);

	localparam int VW = ADDR_BITS - PAGE_BITS;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int SW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
	localparam int EW = 1 + dptt_pkg::SPACE_W + VW + FRAME_BITS;
	localparam int CNT = dptt_pkg::COUNT_W;
	localparam logic [FRAME_BITS-1:0] RESET_FRAME = FRAME_BITS'(dptt_pkg::FIRST_FRAME_RESET);

	dptt_pkg::back_state_t state_q, state_d;

	dptt_pkg::cmd_ctl_t         ctl_q;
	logic [VW:0]                start_q;
	logic [VW:0]                end_q;
	logic [ADDR_BITS-1:0]       addr_q;
	logic [IW:0]                scan_q;
	logic [IW-1:0]              clr_q;
	logic                       rv_s1;
	logic [IW-1:0]              ridx_s1;
	logic                       match_q;
	logic [FRAME_BITS-1:0]      match_frame_q;
	logic                       free_q;
	logic [IW-1:0]              free_idx_q;
	logic [1:0]                 status_q;
	logic [FRAME_BITS-1:0]      next_frame_q;
	logic                       pool_empty_q;
	logic [CNT-1:0]             cnt_q [NUM_SPACES];
	logic [CNT-1:0]             total_q;

	logic                       issue;
	logic                       we;
	logic [IW-1:0]              waddr;
	logic [EW-1:0]              wdata;
	logic [EW-1:0]              rdata;
	logic                       rd_valid;
	logic [dptt_pkg::SPACE_W-1:0] rd_space;
	logic [VW-1:0]              rd_vpn;
	logic [FRAME_BITS-1:0]      rd_frame;
	logic                       vpn_sel;
	logic                       hit_cmp;
	logic                       free_cmp;
	logic                       alloc;
	logic                       unmap_hit;
	logic [SW-1:0]              sidx;
	logic                       step_page;
	logic [1:0]                 status_d;
	logic                       status_we;

	assign rd_valid = rdata[EW-1];
	assign rd_space = rdata[EW-2 -: dptt_pkg::SPACE_W];
	assign rd_vpn   = rdata[FRAME_BITS +: VW];
	assign rd_frame = rdata[FRAME_BITS-1:0];
	assign sidx     = SW'(ctl_q.space);

	assign issue = (state_q == dptt_pkg::BK_SCAN) && (scan_q < (IW+1)'(TABLE_ENTRIES));
	assign vpn_sel = (ctl_q.op == dptt_pkg::CMD_UNMAP)
		? ({1'b0, rd_vpn} >= start_q && {1'b0, rd_vpn} < end_q)
		: (rd_vpn == start_q[VW-1:0]);
	assign hit_cmp  = rv_s1 && rd_valid && (rd_space == ctl_q.space) && vpn_sel;
	assign free_cmp = rv_s1 && !rd_valid;
	assign unmap_hit = (state_q == dptt_pkg::BK_SCAN) && (ctl_q.op == dptt_pkg::CMD_UNMAP)
		&& hit_cmp;
	assign alloc = (state_q == dptt_pkg::BK_POST) && (ctl_q.op == dptt_pkg::CMD_MAP)
		&& !match_q && free_q && !pool_empty_q;
	assign clearing = (state_q == dptt_pkg::BK_CLEAR);

	dptt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(scan_q[IW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (state_q == dptt_pkg::BK_CLEAR) begin
			we = 1'b1;
		end else if (unmap_hit) begin
			we    = 1'b1;
			waddr = ridx_s1;
		end else if (alloc) begin
			we    = 1'b1;
			waddr = free_idx_q;
			wdata = {1'b1, ctl_q.space, start_q[VW-1:0], next_frame_q};
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		step_page = 1'b0;
		status_we = 1'b0;
		status_d  = dptt_pkg::ST_OK;
		unique case (state_q)
			dptt_pkg::BK_CLEAR: begin
				if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
					state_d = dptt_pkg::BK_IDLE;
				end
			end
			dptt_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd_ctl.op)
						dptt_pkg::CMD_TRANS: begin
							state_d = (cmd_ctl.bypass || !cmd_ctl.ok)
								? dptt_pkg::BK_OUT : dptt_pkg::BK_SCAN;
						end
						dptt_pkg::CMD_MAP: begin
							state_d = dptt_pkg::BK_PAGE;
						end
						dptt_pkg::CMD_UNMAP: begin
							state_d = (cmd_start >= cmd_end)
								? dptt_pkg::BK_OUT : dptt_pkg::BK_SCAN;
						end
						default: begin
							state_d = dptt_pkg::BK_OUT;
						end
					endcase
				end
			end
			dptt_pkg::BK_PAGE: begin
				if (start_q >= end_q) begin
					state_d = dptt_pkg::BK_OUT;
				end else if (start_q == '0) begin
					step_page = 1'b1;
				end else begin
					state_d = dptt_pkg::BK_SCAN;
				end
			end
			dptt_pkg::BK_SCAN: begin
				if (!issue && !rv_s1) begin
					state_d = (ctl_q.op == dptt_pkg::CMD_UNMAP)
						? dptt_pkg::BK_OUT : dptt_pkg::BK_POST;
				end
			end
			dptt_pkg::BK_POST: begin
				if (ctl_q.op != dptt_pkg::CMD_MAP) begin
					state_d = dptt_pkg::BK_OUT;
				end else if (match_q) begin
					step_page = 1'b1;
					state_d   = dptt_pkg::BK_PAGE;
				end else if (!free_q) begin
					status_we = 1'b1;
					status_d  = dptt_pkg::ST_FULL;
					state_d   = dptt_pkg::BK_OUT;
				end else if (pool_empty_q) begin
					status_we = 1'b1;
					status_d  = dptt_pkg::ST_EXHAUSTED;
					state_d   = dptt_pkg::BK_OUT;
				end else begin
					step_page = 1'b1;
					state_d   = dptt_pkg::BK_PAGE;
				end
			end
			dptt_pkg::BK_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = dptt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = dptt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dptt_pkg::BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ctl_q    <= cmd_ctl;
			start_q  <= cmd_start;
			end_q    <= cmd_end;
			addr_q   <= cmd_addr;
			status_q <= dptt_pkg::ST_OK;
		end else if (status_we) begin
			status_q <= status_d;
		end else if (step_page) begin
			start_q <= start_q + (VW+1)'(1);
		end
		ridx_s1 <= scan_q[IW-1:0];
		if (hit_cmp && !match_q) begin
			match_frame_q <= rd_frame;
		end
		if (free_cmp && !free_q) begin
			free_idx_q <= ridx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			scan_q       <= '0;
			rv_s1        <= 1'b0;
			match_q      <= 1'b0;
			free_q       <= 1'b0;
			next_frame_q <= RESET_FRAME;
			pool_empty_q <= 1'b0;
			total_q      <= '0;
			for (int i = 0; i < NUM_SPACES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == dptt_pkg::BK_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			rv_s1 <= issue;
			if (state_q == dptt_pkg::BK_SCAN) begin
				if (issue) begin
					scan_q <= scan_q + (IW+1)'(1);
				end
				if (hit_cmp) begin
					match_q <= 1'b1;
				end
				if (free_cmp) begin
					free_q <= 1'b1;
				end
			end else if (state_q != dptt_pkg::BK_POST && state_q != dptt_pkg::BK_OUT) begin
				scan_q  <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end
			if (cfg_write) begin
				next_frame_q <= cfg_data;
				pool_empty_q <= 1'b0;
			end else if (alloc) begin
				if (next_frame_q == {FRAME_BITS{1'b1}}) begin
					pool_empty_q <= 1'b1;
				end else begin
					next_frame_q <= next_frame_q + FRAME_BITS'(1);
				end
			end
			if (alloc) begin
				cnt_q[sidx] <= cnt_q[sidx] + CNT'(1);
				total_q     <= total_q + CNT'(1);
			end else if (unmap_hit) begin
				cnt_q[sidx] <= cnt_q[sidx] - CNT'(1);
				total_q     <= total_q - CNT'(1);
			end
		end
	end

	always_comb begin
		res.phys_address = '0;
		res.hit          = 1'b0;
		if (ctl_q.op == dptt_pkg::CMD_TRANS) begin
			if (ctl_q.bypass) begin
				res.phys_address = dptt_pkg::PHYS_W'(addr_q);
			end else if (match_q) begin
				res.phys_address = dptt_pkg::PHYS_W'({match_frame_q, addr_q[PAGE_BITS-1:0]});
				res.hit          = 1'b1;
			end else begin
				res.phys_address = dptt_pkg::PHYS_W'(addr_q[PAGE_BITS-1:0]);
			end
		end
		res.status      = status_q;
		res.space_pages = ctl_q.ok ? cnt_q[sidx] : '0;
		res.total_pages = total_q;
	end

endmodule

### hw/rtl/demand_page_table_translator.sv
// ----------------------------------------------------------------------------
// demand_page_table_translator
// Per-address-space page table in a bounded associative store.
// ----------------------------------------------------------------------------
// Items are decoded at the input into page range commands and queued; the
// table side executes them one at a time with full passes over the table RAM
// through its single read port. A translate takes one pass, a map or touch
// one pass per page walked that is not page zero (page zero is stepped over
// without a pass), an unmap one pass, and items with no table work (bypass,
// empty ranges, other actions) none. Accepted items reach the table side
// through the command queue, and results reach the ports through the result
// queue. After reset the table is cleared one entry at a time, during which
// full stays high.
module demand_page_table_translator #(
	parameter int NUM_SPACES    = 8,
	parameter int TABLE_ENTRIES = 1024,
	parameter int PAGE_BITS     = 12,
	parameter int ADDR_BITS     = 32,
	parameter int FRAME_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [FRAME_BITS-1:0]             cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [dptt_pkg::ACTION_W-1:0]     action,
	input  logic [dptt_pkg::SPACE_W-1:0]      space_id,
	input  logic                              bypass,
	input  logic [ADDR_BITS-1:0]              address,
	input  logic [dptt_pkg::LEN_W-1:0]        length,
	input  logic                              adjust_break,
	output logic                              empty,
	input  logic                              pop,
	output logic [dptt_pkg::PHYS_W-1:0]       phys_address,
	output logic                              hit,
	output logic [dptt_pkg::STATUS_W-1:0]     status,
	output logic [dptt_pkg::COUNT_W-1:0]      space_pages,
	output logic [dptt_pkg::COUNT_W-1:0]      total_pages
);

	localparam int VW = ADDR_BITS - PAGE_BITS;
	localparam int CMD_W = $bits(dptt_pkg::cmd_ctl_t) + 2 * (VW + 1) + ADDR_BITS;
	localparam int RES_W = $bits(dptt_pkg::result_t);

	dptt_pkg::cmd_ctl_t f_ctl;
	dptt_pkg::cmd_ctl_t b_ctl;
	logic [VW:0]          f_start;
	logic [VW:0]          f_end;
	logic [VW:0]          b_start;
	logic [VW:0]          b_end;
	logic [ADDR_BITS-1:0] b_addr;
	logic                 accept;
	logic                 cmd_full;
	logic                 cmd_empty;
	logic                 cmd_pop;
	logic [CMD_W-1:0]     cmd_rdata;
	logic                 res_push;
	logic                 res_full;
	logic                 clearing;
	dptt_pkg::result_t    b_res;
	dptt_pkg::result_t    out_res;

	assign full   = cmd_full || clearing;
	assign accept = push && !full;

	dptt_front #(
		.NUM_SPACES(NUM_SPACES),
		.PAGE_BITS (PAGE_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.space_id    (space_id),
		.bypass      (bypass),
		.address     (address),
		.length      (length),
		.adjust_break(adjust_break),
		.ctl         (f_ctl),
		.start_vpn   (f_start),
		.end_vpn     (f_end)
	);

	dptt_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (accept),
		.wdata ({f_ctl, f_start, f_end, address}),
		.full  (cmd_full),
		.rd    (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	assign {b_ctl, b_start, b_end, b_addr} = cmd_rdata;

	dptt_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.NUM_SPACES   (NUM_SPACES),
		.PAGE_BITS    (PAGE_BITS),
		.ADDR_BITS    (ADDR_BITS),
		.FRAME_BITS   (FRAME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.cmd_valid(!cmd_empty),
		.cmd_pop  (cmd_pop),
		.cmd_ctl  (b_ctl),
		.cmd_start(b_start),
		.cmd_end  (b_end),
		.cmd_addr (b_addr),
		.res_push (res_push),
		.res_full (res_full),
		.res      (b_res),
		.clearing (clearing)
	);

	dptt_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (b_res),
		.full  (res_full),
		.rd    (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign phys_address = out_res.phys_address;
	assign hit          = out_res.hit;
	assign status       = out_res.status;
	assign space_pages  = out_res.space_pages;
	assign total_pages  = out_res.total_pages;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("item accepted during table clear");

	a_result_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_hit_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hit) |-> (status == dptt_pkg::ST_OK))
		else $error("hit with error status");

endmodule
